### rtl/swcc_pkg.sv
// swcc_pkg: widths, register indexes, reset values and shared types
// for the sliding-window critical counter; no dependencies
package swcc_pkg;

  localparam int unsigned READING_W      = 12;
  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned HIGH_CNT_W     = 3;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned WINDOW_LEN_DEF = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIGH_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVERAGE    = 2'd3;

  localparam logic [READING_W-1:0]  UPPER_LIMIT_RST    = 12'd150;
  localparam logic [READING_W-1:0]  HIGH_LEVEL_RST     = 12'd70;
  localparam logic [HIGH_CNT_W-1:0] MIN_HIGH_COUNT_RST = 3'd3;
  localparam logic [READING_W-1:0]  MIN_AVERAGE_RST    = 12'd90;

  typedef struct packed {
    logic [READING_W-1:0]  upper_limit;
    logic [READING_W-1:0]  high_level;
    logic [HIGH_CNT_W-1:0] min_high_count;
    logic [READING_W-1:0]  min_average;
  } cfg_t;

  // status of the word held in the window stage
  typedef struct packed {
    logic valid;
    logic full;
    logic eos;
  } stage_t;

endpackage

### rtl/swcc_window.sv
// swcc_window: input stage holding the reading shift register and fill level
// depends on swcc_pkg
module swcc_window #(
  parameter int unsigned WINDOW_LEN = swcc_pkg::WINDOW_LEN_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic [swcc_pkg::READING_W-1:0]                 reading_i,
  input  logic                                           end_of_sequence_i,
  input  logic                                           drain_i,
  output swcc_pkg::stage_t                               stage_o,
  output logic [WINDOW_LEN-1:0][swcc_pkg::READING_W-1:0] window_o
);
  import swcc_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_LEN);
  localparam logic [FILL_W-1:0] FULL_AT  = FILL_W'(WINDOW_LEN - 1);

  logic [WINDOW_LEN-1:0][READING_W-1:0] win_q, win_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  stage_t stage_q, stage_d;
  logic take;

  assign in_ready_o = !stage_q.valid || drain_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    stage_d = stage_q;
    if (take) begin
      // newest reading at entry 0
      win_d         = {win_q[WINDOW_LEN-2:0], reading_i};
      stage_d.valid = 1'b1;
      stage_d.full  = (fill_q >= FULL_AT);
      stage_d.eos   = end_of_sequence_i;
      if (end_of_sequence_i) begin
        fill_d = '0;
      end else if (fill_q != FILL_MAX) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (drain_i) begin
      stage_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      stage_q <= '0;
    end else begin
      fill_q  <= fill_d;
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign stage_o  = stage_q;
  assign window_o = win_q;

  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill level beyond window length");

  a_eos_clears_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && end_of_sequence_i |=> fill_q == '0)
    else $error("fill level not cleared after end of sequence");

  a_full_needs_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (fill_q < FULL_AT) |=> !stage_q.full)
    else $error("window marked full too early");

endmodule

### rtl/swcc_judge.sv
// swcc_judge: combinational check of one full window against the limits
// depends on swcc_pkg
module swcc_judge #(
  parameter int unsigned WINDOW_LEN = swcc_pkg::WINDOW_LEN_DEF
) (
  input  logic [WINDOW_LEN-1:0][swcc_pkg::READING_W-1:0] window_i,
  input  swcc_pkg::cfg_t                                 cfg_i,
  output logic                                           critical_o
);
  import swcc_pkg::*;

  localparam int unsigned SUM_W  = READING_W + $clog2(WINDOW_LEN);
  localparam int unsigned HCNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned HC_W   = (HCNT_W > HIGH_CNT_W) ? HCNT_W : HIGH_CNT_W;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] avg_floor;
  logic [HC_W-1:0]  highs;
  logic             over;

  // truncated sum/len >= min_average is the same as sum >= min_average*len
  assign avg_floor = SUM_W'(cfg_i.min_average) * SUM_W'(WINDOW_LEN);

  always_comb begin
    sum   = '0;
    highs = '0;
    over  = 1'b0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sum   = sum + SUM_W'(window_i[i]);
      highs = highs + HC_W'(window_i[i] >= cfg_i.high_level);
      over  = over | (window_i[i] > cfg_i.upper_limit);
    end
  end

  assign critical_o = !over && (highs >= HC_W'(cfg_i.min_high_count)) && (sum >= avg_floor);

endmodule

### rtl/sliding_window_critical_counter_core.sv
// sliding_window_critical_counter_core: top level with config registers,
// critical counter and result register; depends on swcc_pkg, swcc_window, swcc_judge
//
// Takes one reading per cycle on a valid/ready input and gives exactly one
// result per reading on a valid/ready output. There are two register stages.
// The reading enters the window shift register at the edge that accepts it.
// When the window stage advances, the result register is loaded with the
// judgement of that window (adder over the window plus compares) and the
// updated saturating count, and the result is offered from there. Full
// throughput holds as long as the output is taken; ready on the input drops
// only when both the window stage and the result register are occupied and
// the result is not being taken. Limits are to be written on the cfg port
// only while no reading is in flight; the core does not enforce this.
module sliding_window_critical_counter_core #(
  parameter int unsigned WINDOW_LEN = swcc_pkg::WINDOW_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [swcc_pkg::READING_W-1:0]  reading_i,
  input  logic                            end_of_sequence_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            window_full_o,
  output logic                            window_critical_o,
  output logic [swcc_pkg::COUNT_W-1:0]    critical_total_o,
  output logic                            sequence_done_o,
  input  logic                            cfg_we_i,
  input  logic [swcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import swcc_pkg::*;

  cfg_t cfg_q, cfg_d;
  stage_t stage;
  logic [WINDOW_LEN-1:0][READING_W-1:0] window;
  logic critical, crit_hit, drain, advance;
  logic [COUNT_W-1:0] count_q, count_d, total;
  logic out_valid_q, out_valid_d;
  logic full_q, crit_q, eos_q;
  logic [COUNT_W-1:0] total_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UPPER_LIMIT:    cfg_d.upper_limit    = cfg_data_i;
        CFG_HIGH_LEVEL:     cfg_d.high_level     = cfg_data_i;
        CFG_MIN_HIGH_COUNT: cfg_d.min_high_count = cfg_data_i[HIGH_CNT_W-1:0];
        CFG_MIN_AVERAGE:    cfg_d.min_average    = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  swcc_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .reading_i        (reading_i),
    .end_of_sequence_i(end_of_sequence_i),
    .drain_i          (drain),
    .stage_o          (stage),
    .window_o         (window)
  );

  swcc_judge #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_judge (
    .window_i  (window),
    .cfg_i     (cfg_q),
    .critical_o(critical)
  );

  assign drain    = !out_valid_q || out_ready_i;
  assign advance  = drain && stage.valid;
  assign crit_hit = critical && stage.full;
  // saturate at all ones
  assign total    = count_q + COUNT_W'(crit_hit && (count_q != '1));

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      count_d     = stage.eos ? '0 : total;
      out_valid_d = 1'b1;
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_limit    <= UPPER_LIMIT_RST;
      cfg_q.high_level     <= HIGH_LEVEL_RST;
      cfg_q.min_high_count <= MIN_HIGH_COUNT_RST;
      cfg_q.min_average    <= MIN_AVERAGE_RST;
      count_q              <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      full_q  <= stage.full;
      crit_q  <= crit_hit;
      eos_q   <= stage.eos;
      total_q <= total;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign window_full_o     = full_q;
  assign window_critical_o = crit_q;
  assign critical_total_o  = total_q;
  assign sequence_done_o   = eos_q;

  a_crit_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_critical_o |-> window_full_o)
    else $error("critical result from a window that is not full");

  a_crit_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_critical_o |-> critical_total_o != '0)
    else $error("critical window not reflected in total");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
             || (count_q == '0))
    else $error("critical count moved by more than one");

  a_stall_needs_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stage.valid && out_valid_q)
    else $error("input stalled with free stages");

endmodule

### dv/sliding_window_critical_counter_core_tb.sv
// sliding_window_critical_counter_core_tb: self-checking bench for the window
// qualifier core; needs swcc_pkg and the core rtl, nothing else
module sliding_window_critical_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swcc_pkg::*;

  localparam int unsigned WIN_LEN        = WINDOW_LEN_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 40;
  localparam int unsigned DIR_N          = 22;
  localparam int unsigned BURST_LEN      = 50;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic               full;
    logic               crit;
    logic [COUNT_W-1:0] total;
    logic               done;
  } verdict_t;

  typedef struct packed {
    logic [READING_W-1:0] reading;
    logic                 eos;
    logic                 typed;
    verdict_t             want;
  } stim_row_t;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_ready_o;
  logic [READING_W-1:0]  reading_i         = '0;
  logic                  end_of_sequence_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i       = 1'b0;
  logic                  window_full_o;
  logic                  window_critical_o;
  logic [COUNT_W-1:0]    critical_total_o;
  logic                  sequence_done_o;
  logic                  cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i         = CFG_UPPER_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;

  always #5 clk_i = ~clk_i;

  sliding_window_critical_counter_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .reading_i         (reading_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .window_full_o     (window_full_o),
    .window_critical_o (window_critical_o),
    .critical_total_o  (critical_total_o),
    .sequence_done_o   (sequence_done_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  // predictor state
  cfg_t                 limits;
  logic [READING_W-1:0] history [WIN_LEN];
  int unsigned          held;
  logic [COUNT_W-1:0]   crit_tally;

  verdict_t    verdict_q [$];
  int unsigned err_count;
  int unsigned n_words;
  int unsigned n_results;
  int unsigned n_critical;
  int unsigned n_sequences;
  int unsigned n_writes;
  bit          full_rate;
  int unsigned idle_cycles;

  stim_row_t dir_tab [DIR_N];

  function automatic void clear_window();
    for (int i = 0; i < WIN_LEN; i++) history[i] = '0;
    held       = 0;
    crit_tally = '0;
  endfunction

  function automatic verdict_t judge_reading(logic [READING_W-1:0] r, logic eos);
    verdict_t    v;
    int unsigned sum;
    int unsigned highs;
    bit          over;
    v = '0;
    for (int i = WIN_LEN - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = r;
    if (held < WIN_LEN) held++;
    if (held >= WIN_LEN) begin
      sum   = 0;
      highs = 0;
      over  = 1'b0;
      for (int i = 0; i < WIN_LEN; i++) begin
        sum += history[i];
        if (history[i] > limits.upper_limit) over = 1'b1;
        if (history[i] >= limits.high_level) highs++;
      end
      v.full = 1'b1;
      v.crit = !over && (highs >= limits.min_high_count) &&
               ((sum / WIN_LEN) >= limits.min_average);
      if (v.crit && crit_tally != COUNT_TOP) crit_tally++;
    end
    v.total = crit_tally;
    v.done  = eos;
    if (eos) clear_window();
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [READING_W-1:0] near_value(int x);
    int v;
    v = x + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[READING_W-1:0];
  endfunction

  // readings cluster around the limits so that every compare flips
  function automatic logic [READING_W-1:0] pick_reading();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return near_value(int'(limits.upper_limit));
      3:       return near_value(int'(limits.high_level));
      4:       return near_value(int'(limits.min_average));
      5, 6:    return READING_W'($urandom_range(int'(limits.upper_limit),
                                                int'(limits.high_level)));
      7:       return READING_W'($urandom_range(int'(limits.min_average),
                                                int'(limits.upper_limit)));
      default: return READING_W'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_word(logic [READING_W-1:0] r, logic eos, logic typed, verdict_t want);
    int unsigned gap;
    verdict_t    v;
    gap = full_rate ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    reading_i         <= r;
    end_of_sequence_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    v = judge_reading(r, eos);
    verdict_q.push_back(typed ? want : v);
    n_words++;
    if (eos) n_sequences++;
  endtask

  // sender goes quiet until every word in flight has come out
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_UPPER_LIMIT:    limits.upper_limit    = data[READING_W-1:0];
      CFG_HIGH_LEVEL:     limits.high_level     = data[READING_W-1:0];
      CFG_MIN_HIGH_COUNT: limits.min_high_count = data[HIGH_CNT_W-1:0];
      CFG_MIN_AVERAGE:    limits.min_average    = data[READING_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_limits(logic [CFG_DATA_W-1:0] upper, logic [CFG_DATA_W-1:0] high,
                            logic [CFG_DATA_W-1:0] min_high, logic [CFG_DATA_W-1:0] min_avg);
    hold_until_drained();
    // result register may still be settling after the last word
    repeat (3) @(posedge clk_i);
    write_reg(CFG_UPPER_LIMIT, upper);
    write_reg(CFG_HIGH_LEVEL, high);
    write_reg(CFG_MIN_HIGH_COUNT, min_high);
    write_reg(CFG_MIN_AVERAGE, min_avg);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          broken;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      broken = ($urandom_range(0, 4) == 0);
      len    = broken ? $urandom_range(1, WIN_LEN - 1) : $urandom_range(WIN_LEN, 40);
      for (int i = 0; i < len; i++) send_word(pick_reading(), i == len - 1, 1'b0, '0);
      sent += len;
    end
  endtask

  // receiver: runs of ready with stalls of random length
  initial begin
    int unsigned run_len;
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (full_rate) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        run_len = $urandom_range(1, 30);
        stall   = pick_gap();
        out_ready_i <= 1'b1;
        repeat (run_len) @(posedge clk_i);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (window_critical_o) n_critical++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with nothing expected, total",
                          longint'(critical_total_o), 0);
        end else begin
          exp_v = verdict_q.pop_front();
          if (window_full_o !== exp_v.full)
            report_mismatch("window_full", longint'(window_full_o), longint'(exp_v.full));
          if (window_critical_o !== exp_v.crit)
            report_mismatch("window_critical", longint'(window_critical_o),
                            longint'(exp_v.crit));
          if (critical_total_o !== exp_v.total)
            report_mismatch("critical_total", longint'(critical_total_o),
                            longint'(exp_v.total));
          if (sequence_done_o !== exp_v.done)
            report_mismatch("sequence_done", longint'(sequence_done_o),
                            longint'(exp_v.done));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    err_count      = 0;
    n_words        = 0;
    n_results      = 0;
    n_critical     = 0;
    n_sequences    = 0;
    n_writes       = 0;
    idle_cycles    = 0;
    full_rate      = 1'b0;
    limits.upper_limit    = UPPER_LIMIT_RST;
    limits.high_level     = HIGH_LEVEL_RST;
    limits.min_high_count = MIN_HIGH_COUNT_RST;
    limits.min_average    = MIN_AVERAGE_RST;
    clear_window();

    // reset limits: upper 150, high 70, min highs 3, min average 90
    dir_tab = '{
      '{12'd100,  1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd100,  1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd100,  1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd100,  1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd100,  1'b0, 1'b1, '{1'b1, 1'b1, 16'd1, 1'b0}},
      '{12'd4095, 1'b0, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0}},
      '{12'd150,  1'b0, 1'b0, '0},
      '{12'd150,  1'b0, 1'b0, '0},
      '{12'd70,   1'b0, 1'b0, '0},
      '{12'd70,   1'b0, 1'b0, '0},
      // average exactly at the minimum, largest reading exactly at the limit
      '{12'd10,   1'b0, 1'b0, '0},
      '{12'd151,  1'b0, 1'b0, '0},
      '{12'd140,  1'b0, 1'b0, '0},
      '{12'd140,  1'b0, 1'b0, '0},
      '{12'd69,   1'b0, 1'b0, '0},
      '{12'd69,   1'b0, 1'b0, '0},
      '{12'd69,   1'b0, 1'b0, '0},
      '{12'd0,    1'b1, 1'b0, '0},
      // window and count start again after end of sequence
      '{12'd4095, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd0,    1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd2730, 1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
      '{12'd4095, 1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b1}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      send_word(dir_tab[i].reading, dir_tab[i].eos, dir_tab[i].typed, dir_tab[i].want);

    // low extremes, then high extremes with min highs masked down to seven
    set_limits(12'd0, 12'd0, 12'd0, 12'd0);
    random_traffic(140);
    set_limits(12'hfff, 12'hfff, 12'hfff, 12'hfff);
    random_traffic(140);
    set_limits(12'd200, 12'd100, 12'd5, 12'd120);
    random_traffic(140);
    // min highs of six can never be met
    set_limits(12'd150, 12'd70, 12'hff6, 12'd90);
    random_traffic(100);
    for (int p = 0; p < 3; p++) begin
      set_limits(CFG_DATA_W'($urandom_range(1000, 4095)),
                 CFG_DATA_W'($urandom_range(0, 1500)),
                 CFG_DATA_W'($urandom_range(0, 5)),
                 CFG_DATA_W'($urandom_range(0, 1500)));
      random_traffic(140);
    end
    set_limits(UPPER_LIMIT_RST, HIGH_LEVEL_RST, MIN_HIGH_COUNT_RST, MIN_AVERAGE_RST);
    random_traffic(140);

    // every full window critical, words back to back with the output always taken
    set_limits(12'hfff, 12'd0, 12'd0, 12'd0);
    full_rate = 1'b1;
    for (int i = 0; i < BURST_LEN; i++)
      send_word(READING_W'($urandom()), 1'b0, 1'b0, '0);
    send_word(READING_W'($urandom()), 1'b1, 1'b0, '0);
    full_rate = 1'b0;
    random_traffic(40);

    hold_until_drained();
    repeat (4) @(posedge clk_i);

    $display("covered %0d words in %0d sequences, %0d results, %0d critical windows",
             n_words, n_sequences, n_results, n_critical);
    $display("%0d register writes across nine limit sets, one back-to-back burst",
             n_writes);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
